// File: sv/dno_pkg.sv
// ----------------------------------------------------------------------------
// dno_pkg
// Shared constants, types and the font for the decimal number overlay.
// ----------------------------------------------------------------------------
package dno_pkg;

  // Default parameter values
  localparam int DEF_MAX_DIGITS  = 4;
  localparam int DEF_COORD_BITS  = 12;

  // Fixed field widths
  localparam int GLYPH_SIZE      = 12;
  localparam int VALUE_W         = 14;
  localparam int BORDER_W        = 8;
  localparam int BYTE_W          = 8;
  localparam int RGB_W           = 3 * BYTE_W;
  localparam int DEC_DIGITS      = 5;   // digits a 14-bit value can have
  localparam int CNT_W           = 3;   // digit count 0..5
  localparam int DIGIT_W         = 4;
  localparam int GIDX_W          = 4;   // row/column inside a glyph
  localparam int Q100_W          = 8;   // value / 100 <= 163
  localparam int R100_W          = 7;   // value % 100

  // Stream payload layout
  localparam int OUT_DATA_W      = RGB_W;
  localparam int OUT_USER_W      = 2;
  localparam int USER_INKED      = 0;
  localparam int USER_TOO_LARGE  = 1;

  // Config port
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int IMAGE_WIDTH_RST = 640;

  typedef enum logic [2:0] {
    REG_SHOWN_VALUE   = 3'd0,
    REG_ANCHOR_COL    = 3'd1,
    REG_ANCHOR_ROW    = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_BORDER_PIXELS = 3'd4
  } reg_idx_t;

  // Placement geometry
  localparam int ROW_SPLIT   = 24;  // anchor rows above this, less the border, draw below the anchor
  localparam int ROW_BELOW   = 13;
  localparam int ROW_ABOVE   = 3;
  localparam int DIGIT_PITCH = 9;
  localparam int RIGHT_GAP   = 3;
  localparam int LEFT_GAP    = 6;
  localparam int LEFT_OFF    = LEFT_GAP + DIGIT_PITCH;
  localparam int ROOM_PER_DIGIT = 12;

  // Constant division by reciprocal multiply
  localparam int RECIP_100    = 5243;  // exact for x < 43690
  localparam int RECIP_100_SH = 19;
  localparam int RECIP_10     = 205;   // exact for x < 1029
  localparam int RECIP_10_SH  = 11;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_ctl_t;

  // Font: bit [11-c] of row r is glyph cell (r, c), 1 = ink
  localparam logic [GLYPH_SIZE-1:0] GLYPH_ROM [10][GLYPH_SIZE] = '{
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000},
    '{12'b000011111000, 12'b000000100000, 12'b000000100000, 12'b000000100000,
      12'b000000100000, 12'b000000100000, 12'b000000100000, 12'b000000100000,
      12'b000100100000, 12'b000010100000, 12'b000001100000, 12'b000000100000},
    '{12'b000111111000, 12'b000100000000, 12'b000010000000, 12'b000001000000,
      12'b000000100000, 12'b000000010000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000100001000, 12'b000010001000, 12'b000001110000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000001110000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000100001000, 12'b000011110000},
    '{12'b000000001000, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b001111111100, 12'b000100001000, 12'b000010001000,
      12'b000001001000, 12'b000000101000, 12'b000000011000, 12'b000000001000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000100001000, 12'b000111110000, 12'b000100000000,
      12'b000100000000, 12'b000100000000, 12'b000100000000, 12'b000111111000},
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000101110000, 12'b000100000000,
      12'b000100000000, 12'b000100000000, 12'b000100001000, 12'b000011110000},
    '{12'b000000001000, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000001111100, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000100001000, 12'b000111111000},
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000011110000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000011101000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000}
  };

  function automatic logic glyph_bit(logic [DIGIT_W-1:0] d, logic [GIDX_W-1:0] r,
                                     logic [GIDX_W-1:0] c);
    logic [GIDX_W-1:0] bi;
    bi = GIDX_W'(GLYPH_SIZE - 1) - c;
    if (d > DIGIT_W'(9) || r >= GIDX_W'(GLYPH_SIZE) || c >= GIDX_W'(GLYPH_SIZE)) begin
      return 1'b0;
    end
    return GLYPH_ROM[d][r][bi];
  endfunction

  // x / 10 for x < 256
  function automatic logic [BYTE_W-1:0] div10(logic [BYTE_W-1:0] x);
    logic [RECIP_10_SH+BYTE_W-1:0] prod;
    prod = x * BYTE_W'(RECIP_10);
    return prod[RECIP_10_SH +: BYTE_W];
  endfunction

endpackage

// File: sv/dno_regs.sv
// ----------------------------------------------------------------------------
// dno_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module dno_regs #(
  parameter int COORD_BITS = dno_pkg::DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dno_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [dno_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [dno_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output logic [dno_pkg::VALUE_W-1:0]      value_r,
  output logic [COORD_BITS-1:0]            anchor_col_r,
  output logic [COORD_BITS-1:0]            anchor_row_r,
  output logic [COORD_BITS-1:0]            image_width_r,
  output logic [dno_pkg::BORDER_W-1:0]     border_r
);
  import dno_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r       <= '0;
      anchor_col_r  <= '0;
      anchor_row_r  <= '0;
      image_width_r <= COORD_BITS'(IMAGE_WIDTH_RST);
      border_r      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SHOWN_VALUE:   value_r       <= cfg_pwdata[VALUE_W-1:0];
        REG_ANCHOR_COL:    anchor_col_r  <= cfg_pwdata[COORD_BITS-1:0];
        REG_ANCHOR_ROW:    anchor_row_r  <= cfg_pwdata[COORD_BITS-1:0];
        REG_IMAGE_WIDTH:   image_width_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_BORDER_PIXELS: border_r      <= cfg_pwdata[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHOWN_VALUE:   cfg_prdata = CFG_DATA_W'(value_r);
      REG_ANCHOR_COL:    cfg_prdata = CFG_DATA_W'(anchor_col_r);
      REG_ANCHOR_ROW:    cfg_prdata = CFG_DATA_W'(anchor_row_r);
      REG_IMAGE_WIDTH:   cfg_prdata = CFG_DATA_W'(image_width_r);
      REG_BORDER_PIXELS: cfg_prdata = CFG_DATA_W'(border_r);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// File: sv/dno_place.sv
// ----------------------------------------------------------------------------
// dno_place
// Stages 1-2: decimal digit split, digit count and label placement.
// ----------------------------------------------------------------------------
module dno_place #(
  parameter int MAX_DIGITS = dno_pkg::DEF_MAX_DIGITS,
  parameter int COORD_BITS = dno_pkg::DEF_COORD_BITS,
  localparam int SW        = COORD_BITS + 4
) (
  input  logic                                              clk,
  input  dno_pkg::pipe_ctl_t                                ctl,
  input  logic [COORD_BITS-1:0]                             pix_col,
  input  logic [COORD_BITS-1:0]                             pix_row,
  input  logic [dno_pkg::RGB_W-1:0]                         pix_rgb,
  input  logic [dno_pkg::VALUE_W-1:0]                       value,
  input  logic [COORD_BITS-1:0]                             anchor_col,
  input  logic [COORD_BITS-1:0]                             anchor_row,
  input  logic [COORD_BITS-1:0]                             image_width,
  input  logic [dno_pkg::BORDER_W-1:0]                      border,
  output logic [dno_pkg::DEC_DIGITS-1:0][dno_pkg::DIGIT_W-1:0] s2_dig_r,
  output logic [dno_pkg::CNT_W-1:0]                         s2_n_r,
  output logic                                              s2_big_r,
  output logic signed [SW-1:0]                              s2_dr_r,
  output logic signed [SW-1:0]                              s2_tadj_r,
  output logic [dno_pkg::RGB_W-1:0]                         s2_rgb_r
);
  import dno_pkg::*;

  // ---- stage 1 ----
  logic signed [SW-1:0]        col_s, row_s, x_s, y_s, brd_s, w_s, y0_s;
  logic [VALUE_W+12:0]         prod100;
  logic [Q100_W-1:0]           q100;
  logic [CNT_W-1:0]            n_raw;

  logic [Q100_W-1:0]           s1_q100_r;
  logic [R100_W-1:0]           s1_r100_r;
  logic [CNT_W-1:0]            s1_n_r;
  logic                        s1_big_r;
  logic signed [SW-1:0]        s1_dr_r, s1_t_r;
  logic [RGB_W-1:0]            s1_rgb_r;

  assign col_s = SW'(pix_col);
  assign row_s = SW'(pix_row);
  assign x_s   = SW'(anchor_col);
  assign y_s   = SW'(anchor_row);
  assign brd_s = SW'(border);
  assign w_s   = SW'(image_width);

  assign prod100 = value * 13'(RECIP_100);
  assign q100    = prod100[RECIP_100_SH +: Q100_W];
  assign y0_s    = (y_s < SW'(ROW_SPLIT) - brd_s) ? y_s + SW'(ROW_BELOW)
                                                  : y_s - SW'(ROW_ABOVE);

  always_comb begin
    if (value >= VALUE_W'(10000))     n_raw = CNT_W'(5);
    else if (value >= VALUE_W'(1000)) n_raw = CNT_W'(4);
    else if (value >= VALUE_W'(100))  n_raw = CNT_W'(3);
    else if (value >= VALUE_W'(10))   n_raw = CNT_W'(2);
    else if (value != '0)             n_raw = CNT_W'(1);
    else                              n_raw = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      s1_q100_r <= q100;
      s1_r100_r <= R100_W'(value - VALUE_W'(q100) * VALUE_W'(100));
      s1_n_r    <= n_raw;
      s1_big_r  <= 32'(n_raw) > MAX_DIGITS;
      s1_dr_r   <= row_s - y0_s;
      s1_t_r    <= col_s - brd_s - x_s;
      s1_rgb_r  <= pix_rgb;
    end
  end

  // ---- stage 2 ----
  logic [BYTE_W-1:0]    d1, q1000;
  logic signed [SW-1:0] n_s;
  logic                 place_left;

  assign d1         = div10(BYTE_W'(s1_r100_r));
  assign q1000      = div10(s1_q100_r);
  assign n_s        = SW'(s1_n_r);
  // not enough room right of the anchor: label goes left of it
  assign place_left = (w_s - x_s) < (SW'(ROOM_PER_DIGIT) * n_s - brd_s);

  always_ff @(posedge clk) begin
    if (ctl.s2) begin
      s2_dig_r[0] <= DIGIT_W'(BYTE_W'(s1_r100_r) - BYTE_W'(d1 * 4'd10));
      s2_dig_r[1] <= DIGIT_W'(d1);
      s2_dig_r[2] <= DIGIT_W'(s1_q100_r - BYTE_W'(q1000 * 4'd10));
      s2_dig_r[3] <= (q1000 >= BYTE_W'(10)) ? DIGIT_W'(q1000 - BYTE_W'(10))
                                           : DIGIT_W'(q1000);
      s2_dig_r[4] <= (q1000 >= BYTE_W'(10)) ? DIGIT_W'(1) : '0;
      s2_n_r      <= s1_n_r;
      s2_big_r    <= s1_big_r;
      s2_dr_r     <= s1_dr_r;
      s2_tadj_r   <= place_left ? s1_t_r + SW'(LEFT_OFF)
                                : s1_t_r - SW'(RIGHT_GAP)
                                  - SW'(DIGIT_PITCH) * (n_s - SW'(1));
      s2_rgb_r    <= s1_rgb_r;
    end
  end

endmodule

// File: sv/dno_cover.sv
// ----------------------------------------------------------------------------
// dno_cover
// Stages 3-4: per-digit hit test, font lookup and pixel blanking.
// ----------------------------------------------------------------------------
module dno_cover #(
  parameter int MAX_DIGITS = dno_pkg::DEF_MAX_DIGITS,
  parameter int COORD_BITS = dno_pkg::DEF_COORD_BITS,
  localparam int SW        = COORD_BITS + 4
) (
  input  logic                                              clk,
  input  dno_pkg::pipe_ctl_t                                ctl,
  input  logic [dno_pkg::DEC_DIGITS-1:0][dno_pkg::DIGIT_W-1:0] s2_dig,
  input  logic [dno_pkg::CNT_W-1:0]                         s2_n,
  input  logic                                              s2_big,
  input  logic signed [SW-1:0]                              s2_dr,
  input  logic signed [SW-1:0]                              s2_tadj,
  input  logic [dno_pkg::RGB_W-1:0]                         s2_rgb,
  output logic [dno_pkg::RGB_W-1:0]                         out_rgb_r,
  output logic                                              out_ink_r,
  output logic                                              out_big_r
);
  import dno_pkg::*;

  // ---- stage 3: one lane per digit position, counted from the right ----
  logic                                   row_ok;
  logic [MAX_DIGITS-1:0]                  hit_r;
  logic [MAX_DIGITS-1:0][GIDX_W-1:0]      cidx_r;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]     dig_r;
  logic [GIDX_W-1:0]                      ridx_r;
  logic                                   s3_big_r;
  logic [RGB_W-1:0]                       s3_rgb_r;

  assign row_ok = !s2_dr[SW-1] && (s2_dr[SW-2:0] < (SW-1)'(GLYPH_SIZE));

  for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_lane
    logic signed [SW-1:0] dc;
    logic                 col_ok;

    assign dc     = s2_tadj + SW'(DIGIT_PITCH * j);
    assign col_ok = !dc[SW-1] && (dc[SW-2:0] < (SW-1)'(GLYPH_SIZE));

    always_ff @(posedge clk) begin
      if (ctl.s3) begin
        hit_r[j]  <= !s2_big && (s2_n > CNT_W'(j)) && row_ok && col_ok;
        cidx_r[j] <= dc[GIDX_W-1:0];
      end
    end

    if (j < DEC_DIGITS) begin : g_dig
      always_ff @(posedge clk) begin
        if (ctl.s3) dig_r[j] <= s2_dig[j];
      end
    end else begin : g_nodig
      always_ff @(posedge clk) begin
        if (ctl.s3) dig_r[j] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3) begin
      ridx_r   <= s2_dr[GIDX_W-1:0];
      s3_big_r <= s2_big;
      s3_rgb_r <= s2_rgb;
    end
  end

  // ---- stage 4: font lookup, overlapping glyphs OR their ink ----
  logic ink;

  always_comb begin
    ink = 1'b0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      ink = ink | (hit_r[j] & glyph_bit(dig_r[j], ridx_r, cidx_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s4) begin
      out_rgb_r <= ink ? '0 : s3_rgb_r;
      out_ink_r <= ink;
      out_big_r <= s3_big_r;
    end
  end

endmodule

// File: sv/decimal_number_pixel_overlay.sv
// ----------------------------------------------------------------------------
// decimal_number_pixel_overlay
// Draws a configured decimal number onto a pixel stream with a 12x12 font.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one pixel per input
// pixel, in order. There are four register stages (digit split, placement,
// per-digit hit test, font lookup), the last of which is the output
// register. Each stage holds while the one after it is full and stalled, so
// bubbles close up and a waiting result never blocks intake until all four
// stages are occupied. Pixels covered by an ink cell of a glyph leave black
// with inked set; value 0 draws nothing; a value with more than MAX_DIGITS
// digits draws nothing and sets value_too_large. Write registers only while
// the stream is idle; the block does not enforce it. No reset-time sweep.
// ----------------------------------------------------------------------------
module decimal_number_pixel_overlay #(
  parameter int MAX_DIGITS  = dno_pkg::DEF_MAX_DIGITS,
  parameter int COORD_BITS  = dno_pkg::DEF_COORD_BITS,
  localparam int IN_W       = ((2 * COORD_BITS + dno_pkg::RGB_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dno_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [dno_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [dno_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_col, pixel_row, in_red, in_green, in_blue, zero pad
  input  logic [IN_W-1:0]                     in_tdata,
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_red, out_green, out_blue
  output logic [dno_pkg::OUT_DATA_W-1:0]      out_tdata,
  // inked, value_too_large
  output logic [dno_pkg::OUT_USER_W-1:0]      out_tuser
);
  import dno_pkg::*;

  localparam int SW     = COORD_BITS + 4;
  localparam int NSTAGE = 4;

  // config
  logic [VALUE_W-1:0]    value_r;
  logic [COORD_BITS-1:0] anchor_col_r, anchor_row_r, image_width_r;
  logic [BORDER_W-1:0]   border_r;

  dno_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .value_r       (value_r),
    .anchor_col_r  (anchor_col_r),
    .anchor_row_r  (anchor_row_r),
    .image_width_r (image_width_r),
    .border_r      (border_r)
  );

  // Pipeline control: a stage can load when it is empty or its
  // successor loads this cycle. Valid bits follow the data.
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] rdy;
  pipe_ctl_t         ctl;

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_tready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_tvalid;
    for (int s = 1; s < NSTAGE; s++) begin
      if (rdy[s]) vld_nxt[s] = vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload registers load only on a real transaction into the stage
  assign ctl.s1 = rdy[0] && in_tvalid;
  assign ctl.s2 = rdy[1] && vld_r[0];
  assign ctl.s3 = rdy[2] && vld_r[1];
  assign ctl.s4 = rdy[3] && vld_r[2];

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTAGE-1];

  // input unpacking
  logic [COORD_BITS-1:0] pix_col, pix_row;
  logic [RGB_W-1:0]      pix_rgb;

  assign pix_col = in_tdata[COORD_BITS-1:0];
  assign pix_row = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pix_rgb = in_tdata[2*COORD_BITS +: RGB_W];

  // stages 1-2
  logic [DEC_DIGITS-1:0][DIGIT_W-1:0] s2_dig_r;
  logic [CNT_W-1:0]                   s2_n_r;
  logic                               s2_big_r;
  logic signed [SW-1:0]               s2_dr_r, s2_tadj_r;
  logic [RGB_W-1:0]                   s2_rgb_r;

  dno_place #(.MAX_DIGITS(MAX_DIGITS), .COORD_BITS(COORD_BITS)) u_place (
    .clk         (clk),
    .ctl         (ctl),
    .pix_col     (pix_col),
    .pix_row     (pix_row),
    .pix_rgb     (pix_rgb),
    .value       (value_r),
    .anchor_col  (anchor_col_r),
    .anchor_row  (anchor_row_r),
    .image_width (image_width_r),
    .border      (border_r),
    .s2_dig_r    (s2_dig_r),
    .s2_n_r      (s2_n_r),
    .s2_big_r    (s2_big_r),
    .s2_dr_r     (s2_dr_r),
    .s2_tadj_r   (s2_tadj_r),
    .s2_rgb_r    (s2_rgb_r)
  );

  // stages 3-4
  logic [RGB_W-1:0] out_rgb_r;
  logic             out_ink_r, out_big_r;

  dno_cover #(.MAX_DIGITS(MAX_DIGITS), .COORD_BITS(COORD_BITS)) u_cover (
    .clk       (clk),
    .ctl       (ctl),
    .s2_dig    (s2_dig_r),
    .s2_n      (s2_n_r),
    .s2_big    (s2_big_r),
    .s2_dr     (s2_dr_r),
    .s2_tadj   (s2_tadj_r),
    .s2_rgb    (s2_rgb_r),
    .out_rgb_r (out_rgb_r),
    .out_ink_r (out_ink_r),
    .out_big_r (out_big_r)
  );

  assign out_tdata                 = out_rgb_r;
  assign out_tuser[USER_INKED]     = out_ink_r;
  assign out_tuser[USER_TOO_LARGE] = out_big_r;

endmodule

// File: sv/dno_checker.sv
// ----------------------------------------------------------------------------
// dno_checker
// Port-level assertions for the decimal number overlay, bound to the top.
// ----------------------------------------------------------------------------
module dno_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dno_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dno_pkg::OUT_USER_W-1:0] out_tuser
);
  import dno_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // inked pixel leaves black
  a_ink_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_INKED] |-> out_tdata == '0)
    else $error("inked pixel not black");

  // oversized value never draws
  a_big_no_ink: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_TOO_LARGE] |-> !out_tuser[USER_INKED])
    else $error("ink drawn for oversized value");

  // free output side never stalls intake
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("intake stalled with output ready");

  // an intake transaction with the output side ready throughout yields a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind decimal_number_pixel_overlay dno_checker u_dno_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/dno_overlay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dno_overlay_checker
// Watches the config port and both pixel streams, predicts each overlaid
// pixel from its own copy of the label registers and compares in order.
// ----------------------------------------------------------------------------
module dno_overlay_checker #(
  parameter int IN_W = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dno_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [dno_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input  logic                               cfg_pready,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [dno_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic [dno_pkg::OUT_USER_W-1:0]     out_tuser,
  output int                                 mismatch_count,
  output int                                 pixels_in_flight
);
  import dno_pkg::*;

  localparam int DIGITS    = DEF_MAX_DIGITS;
  localparam int LABEL_MAX = 10 ** DIGITS - 1;
  localparam int GLYPH_W   = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       inked;
    logic       too_large;
  } overlay_px_t;

  // Font rows, leftmost cell in the top bit; 1 = ink.
  localparam logic [GLYPH_W-1:0] DIGIT_FONT [10][GLYPH_W] = '{
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000},
    '{12'b000011111000, 12'b000000100000, 12'b000000100000, 12'b000000100000,
      12'b000000100000, 12'b000000100000, 12'b000000100000, 12'b000000100000,
      12'b000100100000, 12'b000010100000, 12'b000001100000, 12'b000000100000},
    '{12'b000111111000, 12'b000100000000, 12'b000010000000, 12'b000001000000,
      12'b000000100000, 12'b000000010000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000100001000, 12'b000010001000, 12'b000001110000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000001110000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000100001000, 12'b000011110000},
    '{12'b000000001000, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b001111111100, 12'b000100001000, 12'b000010001000,
      12'b000001001000, 12'b000000101000, 12'b000000011000, 12'b000000001000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000100001000, 12'b000111110000, 12'b000100000000,
      12'b000100000000, 12'b000100000000, 12'b000100000000, 12'b000111111000},
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000101110000, 12'b000100000000,
      12'b000100000000, 12'b000100000000, 12'b000100001000, 12'b000011110000},
    '{12'b000000001000, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000001111100, 12'b000000001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000100001000, 12'b000111111000},
    '{12'b000011110000, 12'b000100001000, 12'b000100001000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000011110000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000},
    '{12'b000011110000, 12'b000100001000, 12'b000000001000, 12'b000000001000,
      12'b000000001000, 12'b000000001000, 12'b000011101000, 12'b000100001000,
      12'b000100001000, 12'b000100001000, 12'b000100001000, 12'b000011110000}
  };

  // label registers as seen on the config port
  logic [13:0] lbl_value;
  logic [11:0] lbl_col;
  logic [11:0] lbl_row;
  logic [11:0] lbl_width;
  logic [7:0]  lbl_border;

  overlay_px_t expected_pixels [$];
  int          errs;

  function automatic overlay_px_t overlay_pixel(logic [11:0] col, logic [11:0] row,
                                                logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b);
    overlay_px_t px;
    int          digit [DIGITS];
    int          ndig, rest, k, xa, ya, wid, brd, cx, cy, glyph_top, x0, dc, dr;
    logic        left_side;
    px.red       = r;
    px.green     = g;
    px.blue      = b;
    px.inked     = 1'b0;
    px.too_large = lbl_value > LABEL_MAX;
    xa   = lbl_col;
    ya   = lbl_row;
    wid  = lbl_width;
    brd  = lbl_border;
    cx   = col;
    cy   = row;
    ndig = 0;
    if (!px.too_large) begin
      rest = lbl_value;
      while (rest > 0) begin
        ndig++;
        rest = rest / 10;
      end
      rest = lbl_value;
      for (k = ndig - 1; k >= 0; k--) begin
        digit[k] = rest % 10;
        rest     = rest / 10;
      end
    end
    // label sits below the anchor near the top edge, above it otherwise
    glyph_top = (ya < 24 - brd) ? ya + 13 : ya - 3;
    // too little room on the right: digits go left of the anchor
    left_side = (wid - xa) < (12 * ndig - brd);
    for (k = 0; k < ndig; k++) begin
      x0 = left_side ? xa - 6 - 9 * (ndig - k) : xa + 3 + 9 * k;
      dc = cx - (x0 + brd);
      dr = cy - glyph_top;
      if (dc >= 0 && dc < GLYPH_W && dr >= 0 && dr < GLYPH_W &&
          DIGIT_FONT[digit[k]][dr][GLYPH_W-1-dc]) begin
        px.inked = 1'b1;
      end
    end
    if (px.inked) begin
      px.red   = 8'd0;
      px.green = 8'd0;
      px.blue  = 8'd0;
    end
    return px;
  endfunction

  task automatic compare_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    overlay_px_t want, got;
    if (!rst_n) begin
      lbl_value  = '0;
      lbl_col    = '0;
      lbl_row    = '0;
      lbl_width  = 12'(IMAGE_WIDTH_RST);
      lbl_border = '0;
      errs       = 0;
      expected_pixels.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.red       = out_tdata[7:0];
        got.green     = out_tdata[15:8];
        got.blue      = out_tdata[23:16];
        got.inked     = out_tuser[USER_INKED];
        got.too_large = out_tuser[USER_TOO_LARGE];
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel out with none expected, expected nothing, got %h / %b",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("out_red", want.red, got.red);
          compare_field("out_green", want.green, got.green);
          compare_field("out_blue", want.blue, got.blue);
          compare_field("inked", want.inked, got.inked);
          compare_field("value_too_large", want.too_large, got.too_large);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(overlay_pixel(in_tdata[11:0], in_tdata[23:12],
                                                in_tdata[31:24], in_tdata[39:32],
                                                in_tdata[47:40]));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_SHOWN_VALUE:   lbl_value  = cfg_pwdata[13:0];
          REG_ANCHOR_COL:    lbl_col    = cfg_pwdata[11:0];
          REG_ANCHOR_ROW:    lbl_row    = cfg_pwdata[11:0];
          REG_IMAGE_WIDTH:   lbl_width  = cfg_pwdata[11:0];
          REG_BORDER_PIXELS: lbl_border = cfg_pwdata[7:0];
          default: ;
        endcase
      end
    end
    pixels_in_flight <= expected_pixels.size();
    mismatch_count   <= errs;
  end

endmodule

// File: bench/decimal_number_pixel_overlay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_pixel_overlay_tb
// Programs label settings over the config port, streams pixels around the
// label and lets the checker compare every output pixel with its prediction.
// ----------------------------------------------------------------------------
module decimal_number_pixel_overlay_tb;
  import dno_pkg::*;

  localparam int IN_W           = ((2 * DEF_COORD_BITS + RGB_W + 7) / 8) * 8;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 48;
  localparam int WATCHDOG_LIMIT = 500;
  // index 5: past the end of the register list, must be ignored
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(20);

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  // pixel_col, pixel_row, in_red, in_green, in_blue
  logic [IN_W-1:0]         in_tdata    = '0;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  // out_red, out_green, out_blue
  logic [OUT_DATA_W-1:0]   out_tdata;
  // inked, value_too_large
  logic [OUT_USER_W-1:0]   out_tuser;

  int   mismatch_count;
  int   pixels_in_flight;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  logic quiet       = 1'b0;   // no random idling on either side while set

  // where the current label sits, used to aim pixels at it
  int aim_col, aim_row, aim_brd;

  always #10 clk = ~clk;

  decimal_number_pixel_overlay DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  dno_overlay_checker #(.IN_W(IN_W)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Result side backpressure: random stall bursts.
  // stall_left is private to this block, hence the blocking updates.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_tready <= (stall_left == 0);
  end

  // Watchdog: any transaction on either stream or the config port
  // restarts the count; a long silence means the block is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Setup then access phase. The bus is left in the access phase so that a
  // following write can start in the very next cycle; cfg_bus_idle parks it.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic cfg_bus_idle();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Program all five label registers; only called with the stream drained.
  task automatic set_label(input logic [31:0] val, input int col, input int row,
                           input int wid, input int brd);
    write_reg({REG_SHOWN_VALUE, 2'b00}, val);
    write_reg({REG_ANCHOR_COL, 2'b00}, 32'(col));
    write_reg({REG_ANCHOR_ROW, 2'b00}, 32'(row));
    write_reg({REG_IMAGE_WIDTH, 2'b00}, 32'(wid));
    write_reg({REG_BORDER_PIXELS, 2'b00}, 32'(brd));
    cfg_bus_idle();
    aim_col = col;
    aim_row = row;
    aim_brd = brd;
  endtask

  // One pixel transaction, optionally preceded by an idle burst. tvalid stays
  // high after acceptance so back-to-back pixels need no extra assignment.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r, row, col};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly pixels in a window around the label, the rest anywhere.
  task automatic send_random_pixel();
    int c, r;
    if ($urandom_range(0, 3) == 0) begin
      send_pixel(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end else begin
      c = aim_col + aim_brd + $urandom_range(0, 100) - 50;
      r = aim_row + $urandom_range(0, 34) - 6;
      send_pixel(12'(c), 12'(r), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Stop the stream and wait until every predicted pixel has come out.
  // The first edge lets the checker count the last accepted pixel.
  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
  endtask

  task automatic pick_random_label(input int phase);
    logic [31:0] val;
    int          wid, brd, col, row;
    wid = (phase == 0) ? 4095 : $urandom_range(16, 700);
    if (phase == 1) begin
      brd = 255;
    end else if ($urandom_range(0, 3) == 0) begin
      brd = $urandom_range(0, 255);
    end else begin
      brd = $urandom_range(0, 20);
    end
    // spread over digit counts, with zero and oversized values mixed in
    case ($urandom_range(0, 9))
      0:       val = 0;
      1:       val = $urandom_range(10000, 16383);
      2, 3:    val = $urandom_range(1, 9);
      4, 5:    val = $urandom_range(10, 99);
      6:       val = $urandom_range(100, 999);
      default: val = $urandom_range(1000, 9999);
    endcase
    // junk above the register width must be dropped by the block
    if ($urandom_range(0, 3) == 0) begin
      val[31:16] = 16'($urandom);
    end
    col = $urandom_range(0, wid + 16) & 12'hFFF;
    row = $urandom_range(0, 64);
    set_label(val, col, row, wid, brd);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: value 0 draws nothing; field extremes pass through
    aim_col = 0;
    aim_row = 0;
    aim_brd = 0;
    send_pixel(12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'hFFF, 12'hFFF, 8'h00, 8'h00, 8'h00);
    drain_pixels();

    // four digits right of the anchor, label above it; high junk bits
    set_label(32'hABCD_0000 | 32'd9999, 100, 50, 640, 0);
    send_pixel(12'd107, 12'd47, 8'hA5, 8'h5A, 8'hC3);
    send_pixel(12'd116, 12'd47, 8'h12, 8'h34, 8'h56);
    send_pixel(12'd103, 12'd52, 8'h80, 8'h01, 8'h7F);
    send_pixel(12'd111, 12'd52, 8'hFF, 8'h00, 8'hFF);
    drain_pixels();

    // values with too many digits draw nothing and raise the flag
    set_label(32'd10000, 100, 50, 640, 0);
    send_pixel(12'd107, 12'd47, 8'h11, 8'h22, 8'h33);
    drain_pixels();
    set_label(32'd16383, 100, 50, 640, 0);
    send_pixel(12'd111, 12'd52, 8'h44, 8'h55, 8'h66);
    drain_pixels();

    // near the right edge: digits move left; anchor near top: label below
    set_label(32'd57, 630, 5, 640, 0);
    send_pixel(12'd610, 12'd18, 8'hDE, 8'hAD, 8'hBE);
    send_pixel(12'd619, 12'd18, 8'hEF, 8'h01, 8'h02);
    send_pixel(12'd618, 12'd24, 8'h03, 8'h04, 8'h05);
    drain_pixels();

    // border shifts columns and thresholds; leftmost glyphs clipped
    set_label(32'd1234, 2, 4, 10, 30);
    send_pixel(12'd0, 12'd1, 8'h99, 8'h88, 8'h77);
    send_pixel(12'd1, 12'd1, 8'h66, 8'h55, 8'h44);
    send_pixel(12'd12, 12'd1, 8'h33, 8'h22, 8'h11);
    send_pixel(12'd21, 12'd6, 8'hF0, 8'h0F, 8'hAA);
    drain_pixels();

    // a write past the register list, then register extremes and zero width
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
    set_label(32'd1, 4095, 4095, 0, 255);
    send_pixel(12'hFFF, 12'hFFF, 8'hC0, 8'hDE, 8'h42);
    send_pixel(12'd4080, 12'd4092, 8'h01, 8'h80, 8'hFE);
    drain_pixels();

    // random label settings, one batch of pixels each; the middle phase
    // and the final one run without idling on either side
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      quiet <= (phase == 3) || (phase == RAND_PHASES - 1);
      pick_random_label(phase);
      repeat (PHASE_ITEMS) send_random_pixel();
      drain_pixels();
    end

    // let any stray output show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pixels_in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
